### hdl/gbcm_pkg.sv
// Shared types and constants for the box covering unit.
// Used by graph_box_covering_memb_unit; no dependencies.
package gbcm_pkg;

    localparam int NODE_AW   = 10;
    localparam int MAX_NODES = 1 << NODE_AW;
    localparam int LINK_AW   = 13;
    localparam int LINK_W    = LINK_AW + 1;
    localparam int BOX_W     = 12;
    localparam int CNT_W     = NODE_AW + 1;
    localparam int RAD_W     = 7;
    localparam int HOP_W     = 8;

    localparam logic [LINK_W-1:0] LINK_NULL  = LINK_W'(1 << LINK_AW);
    localparam logic [LINK_W-1:0] LINK_LIMIT = LINK_W'((1 << LINK_AW) - 2);
    localparam logic [BOX_W-1:0]  BOX_UNCOV  = '1;
    localparam logic [CNT_W-1:0]  NODE_CAP   = CNT_W'(MAX_NODES);

    // Commands
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_RUN   = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REJECT   = 2'd1;
    localparam logic [1:0] ST_UNASSIGN = 2'd2;

    // Register indexes
    localparam logic CFG_RADIUS = 1'b0;
    localparam logic CFG_NODES  = 1'b1;

    typedef struct packed {
        logic [BOX_W-1:0] box;
        logic [RAD_W-1:0] cdist;
        logic [HOP_W-1:0] hop;
    } node_t;

    typedef struct packed {
        logic [LINK_W-1:0] head;
        logic [LINK_W-1:0] tail;
    } ht_t;

endpackage

### hdl/graph_box_covering_memb_unit.sv
// Box covering unit: adjacency store, burning search sequencer and box readout.
// Depends on gbcm_pkg.
//
// Edges go into per-node linked lists held in synchronous RAMs (link targets,
// link next pointers, list head/tail, per-node record, burnt marks, search
// queue), all driven by one sequencer that reads an entry, registers the read
// data and writes back. Only one access to a given entry is in flight at a time.
// After reset, and for a clear command, a clearing pass walks the node, burnt
// mark and list head/tail RAMs; no transaction is accepted meanwhile. A
// rejected add edge or an out-of-range read goes straight to its response. A
// run takes as long as the graph needs: each burning search walks its queued
// nodes and their links and then unmarks every queued node, one search per
// non-centre node each round, with one round per box plus a final one, then a
// distance pass, radius passes and an unassigned scan over all nodes. Results
// sit in an output register, so the next command is taken while a result waits.
module graph_box_covering_memb_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic [9:0]  node_a,
    input  logic [9:0]  node_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [10:0] box_id,
    output logic [10:0] box_count
);

    typedef enum logic [5:0] {
        S_CLR, S_IDLE, S_PUT,
        S_ADD_RD, S_ADD_WR, S_ADD_LNK,
        S_RD_ISS, S_RD_WAIT,
        S_INIT,
        S_MP_RD, S_MP_CHK, S_MP_END, S_MK_RD, S_MK_CHK, S_MK_END,
        S_DP_RD, S_DP_CHK, S_DP_END,
        S_AS_RD, S_AS_CHK, S_AS_EDGE, S_AS_TGT, S_AS_NODE,
        S_FN_RD, S_FN_CHK,
        S_B_START, S_B_POP, S_B_POPW, S_B_TREC, S_B_EDGE, S_B_TGT, S_B_NODE,
        S_U_RD, S_U_WR
    } state_t;

    typedef enum logic [1:0] {M_MASS, M_MARK, M_DIST} mode_t;

    state_t state_reg;
    mode_t  mode_reg;

    // Memories
    gbcm_pkg::node_t                   node_mem [gbcm_pkg::MAX_NODES];
    logic                              burn_mem [gbcm_pkg::MAX_NODES];
    gbcm_pkg::ht_t                     ht_mem   [gbcm_pkg::MAX_NODES];
    logic [gbcm_pkg::NODE_AW-1:0]      tgt_mem  [1 << gbcm_pkg::LINK_AW];
    logic [gbcm_pkg::LINK_W-1:0]       nxt_mem  [1 << gbcm_pkg::LINK_AW];
    logic [gbcm_pkg::NODE_AW-1:0]      q_mem    [gbcm_pkg::MAX_NODES];

    logic [gbcm_pkg::NODE_AW-1:0] node_ra, node_wa, burn_ra, burn_wa, ht_ra, ht_wa;
    logic [gbcm_pkg::NODE_AW-1:0] q_ra, q_wa, q_wd, q_rd, tgt_wd, tgt_rd;
    logic [gbcm_pkg::LINK_AW-1:0] tgt_ra, tgt_wa, nxt_ra, nxt_wa;
    logic [gbcm_pkg::LINK_W-1:0]  nxt_wd, nxt_rd;
    gbcm_pkg::node_t              node_wd, node_rd;
    gbcm_pkg::ht_t                ht_wd, ht_rd;
    logic node_we, burn_we, burn_wd, burn_rd, ht_we, tgt_we, nxt_we, q_we;

    // Control registers
    logic [gbcm_pkg::CNT_W-1:0]   idx_reg, qlen_reg, qhead_reg, mass_reg, best_reg;
    logic [gbcm_pkg::CNT_W-1:0]   nb_reg, boxes_reg;
    logic [gbcm_pkg::NODE_AW-1:0] src_reg, best_id_reg, h_reg, a_reg, b_reg;
    logic [gbcm_pkg::LINK_W-1:0]  edge_reg, nxt_reg, edge_used_reg;
    logic [gbcm_pkg::HOP_W-1:0]   hopt_reg;
    logic [gbcm_pkg::RAD_W-1:0]   mini_reg, t_reg, radius_reg;
    logic [gbcm_pkg::CNT_W-1:0]   ncount_reg;
    gbcm_pkg::node_t              rec_reg;
    logic                         any_unc_reg, unseen_reg, fn_unc_reg, ph_reg, clr_resp_reg;
    logic [1:0]                   rs_status_reg;
    logic [10:0]                  rs_box_reg;
    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [10:0]                  box_id_reg, box_count_reg;

    logic [gbcm_pkg::CNT_W-1:0]  n_eff;
    logic [gbcm_pkg::NODE_AW-1:0] from_node, to_node;
    logic [gbcm_pkg::HOP_W-1:0]  hop_new;
    logic                        box_pos_rd, idx_end, sweep_end;

    assign n_eff      = (ncount_reg > gbcm_pkg::NODE_CAP) ? gbcm_pkg::NODE_CAP : ncount_reg;
    assign from_node  = ph_reg ? b_reg : a_reg;
    assign to_node    = ph_reg ? a_reg : b_reg;
    assign hop_new    = hopt_reg + 8'd1;
    assign box_pos_rd = !node_rd.box[gbcm_pkg::BOX_W-1] && (node_rd.box != '0);
    assign idx_end    = (idx_reg == n_eff);
    assign sweep_end  = (idx_reg == gbcm_pkg::NODE_CAP - 11'd1);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign box_id    = box_id_reg;
    assign box_count = box_count_reg;

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (node_we) node_mem[node_wa] <= node_wd;
        node_rd <= node_mem[node_ra];
        if (burn_we) burn_mem[burn_wa] <= burn_wd;
        burn_rd <= burn_mem[burn_ra];
        if (ht_we) ht_mem[ht_wa] <= ht_wd;
        ht_rd <= ht_mem[ht_ra];
        if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
        tgt_rd <= tgt_mem[tgt_ra];
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        nxt_rd <= nxt_mem[nxt_ra];
        if (q_we) q_mem[q_wa] <= q_wd;
        q_rd <= q_mem[q_ra];
    end

    // Memory address and write control
    always_comb
    begin
        node_we = 1'b0; node_ra = '0; node_wa = '0; node_wd = '0;
        burn_we = 1'b0; burn_ra = '0; burn_wa = '0; burn_wd = 1'b0;
        ht_we   = 1'b0; ht_ra   = '0; ht_wa   = '0; ht_wd   = '0;
        tgt_we  = 1'b0; tgt_ra  = '0; tgt_wa  = '0; tgt_wd  = '0;
        nxt_we  = 1'b0; nxt_ra  = '0; nxt_wa  = '0; nxt_wd  = '0;
        q_we    = 1'b0; q_ra    = '0; q_wa    = '0; q_wd    = '0;
        unique case (state_reg)
            S_CLR:
            begin
                ht_we   = 1'b1; ht_wa = idx_reg[9:0];
                ht_wd   = '{head: gbcm_pkg::LINK_NULL, tail: gbcm_pkg::LINK_NULL};
                node_we = 1'b1; node_wa = idx_reg[9:0];
                node_wd = '{box: gbcm_pkg::BOX_UNCOV, cdist: '0, hop: '0};
                burn_we = 1'b1; burn_wa = idx_reg[9:0]; burn_wd = 1'b0;
            end
            S_INIT:
            begin
                node_we = 1'b1; node_wa = idx_reg[9:0];
                node_wd = '{box: gbcm_pkg::BOX_UNCOV, cdist: '0, hop: '0};
            end
            S_ADD_RD: ht_ra = from_node;
            S_ADD_WR:
            begin
                tgt_we = 1'b1; tgt_wa = edge_used_reg[12:0]; tgt_wd = to_node;
                nxt_we = 1'b1; nxt_wa = edge_used_reg[12:0]; nxt_wd = gbcm_pkg::LINK_NULL;
                ht_we  = 1'b1; ht_wa  = from_node;
                ht_wd.head = (ht_rd.tail == gbcm_pkg::LINK_NULL) ? edge_used_reg : ht_rd.head;
                ht_wd.tail = edge_used_reg;
            end
            S_ADD_LNK:
            begin
                nxt_we = 1'b1; nxt_wa = nxt_reg[12:0]; nxt_wd = edge_reg;
            end
            S_RD_ISS: node_ra = a_reg;
            S_MP_RD, S_DP_RD, S_FN_RD: node_ra = idx_reg[9:0];
            S_AS_RD:
            begin
                node_ra = idx_reg[9:0];
                ht_ra   = idx_reg[9:0];
            end
            S_MK_RD: node_ra = best_id_reg;
            S_DP_END:
            begin
                node_we = 1'b1; node_wa = src_reg;
                node_wd = '{box: rec_reg.box, cdist: mini_reg, hop: '0};
            end
            S_AS_EDGE, S_B_EDGE:
            begin
                tgt_ra = edge_reg[12:0];
                nxt_ra = edge_reg[12:0];
            end
            S_AS_TGT: node_ra = tgt_rd;
            S_AS_NODE:
            begin
                node_we = (node_rd.cdist < t_reg) && box_pos_rd;
                node_wa = idx_reg[9:0];
                node_wd = '{box: node_rd.box, cdist: rec_reg.cdist, hop: rec_reg.hop};
            end
            S_B_START:
            begin
                q_we    = 1'b1; q_wa = '0; q_wd = src_reg;
                burn_we = 1'b1; burn_wa = src_reg; burn_wd = 1'b1;
                node_we = 1'b1; node_wa = src_reg;
                node_wd = '{box: (mode_reg == M_MARK) ? {1'b0, nb_reg} : rec_reg.box,
                            cdist: rec_reg.cdist, hop: '0};
            end
            S_B_POP, S_U_RD: q_ra = qhead_reg[9:0];
            S_B_POPW:
            begin
                node_ra = q_rd;
                ht_ra   = q_rd;
            end
            S_B_TGT:
            begin
                node_ra = tgt_rd;
                burn_ra = tgt_rd;
            end
            S_B_NODE:
            begin
                if (!burn_rd)
                begin
                    burn_we = 1'b1; burn_wa = h_reg; burn_wd = 1'b1;
                    q_we    = 1'b1; q_wa = qlen_reg[9:0]; q_wd = h_reg;
                    node_we = 1'b1; node_wa = h_reg;
                    node_wd.box   = (mode_reg == M_MARK && node_rd.box[11]) ? '0 : node_rd.box;
                    node_wd.cdist = node_rd.cdist;
                    node_wd.hop   = hop_new;
                end
            end
            S_U_WR:
            begin
                burn_we = 1'b1; burn_wa = q_rd; burn_wd = 1'b0;
            end
            default: ;
        endcase
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            mode_reg      <= M_MASS;
            idx_reg       <= '0;
            qlen_reg      <= '0;
            qhead_reg     <= '0;
            mass_reg      <= '0;
            best_reg      <= '0;
            best_id_reg   <= '0;
            nb_reg        <= '0;
            boxes_reg     <= '0;
            edge_used_reg <= '0;
            t_reg         <= '0;
            radius_reg    <= 7'd1;
            ncount_reg    <= 11'd1;
            any_unc_reg   <= 1'b0;
            unseen_reg    <= 1'b0;
            fn_unc_reg    <= 1'b0;
            ph_reg        <= 1'b0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // Configuration writes
            if (cfg_we)
            begin
                if (cfg_index == gbcm_pkg::CFG_RADIUS)
                    radius_reg <= cfg_data[6:0];
                else
                    ncount_reg <= cfg_data;
            end

            // Output register drains; S_PUT reloads it itself
            if (out_valid_reg && out_ready && state_reg != S_PUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLR:
                begin
                    idx_reg <= idx_reg + 11'd1;
                    if (sweep_end)
                    begin
                        edge_used_reg <= '0;
                        boxes_reg     <= '0;
                        unseen_reg    <= 1'b0;
                        rs_status_reg <= gbcm_pkg::ST_OK;
                        rs_box_reg    <= '0;
                        state_reg     <= clr_resp_reg ? S_PUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg      <= node_a;
                        b_reg      <= node_b;
                        ph_reg     <= 1'b0;
                        idx_reg    <= '0;
                        rs_box_reg <= '0;
                        unique case (cmd)
                            gbcm_pkg::CMD_ADD:
                            begin
                                if ({1'b0, node_a} >= n_eff || {1'b0, node_b} >= n_eff ||
                                    edge_used_reg > gbcm_pkg::LINK_LIMIT)
                                begin
                                    rs_status_reg <= gbcm_pkg::ST_REJECT;
                                    state_reg     <= S_PUT;
                                end
                                else
                                begin
                                    rs_status_reg <= gbcm_pkg::ST_OK;
                                    state_reg     <= S_ADD_RD;
                                end
                            end
                            gbcm_pkg::CMD_RUN:
                                state_reg <= S_INIT;
                            gbcm_pkg::CMD_READ:
                            begin
                                rs_status_reg <= unseen_reg ? gbcm_pkg::ST_UNASSIGN :
                                                              gbcm_pkg::ST_OK;
                                state_reg <= ({1'b0, node_a} >= n_eff) ? S_PUT : S_RD_ISS;
                            end
                            gbcm_pkg::CMD_CLEAR:
                            begin
                                clr_resp_reg <= 1'b1;
                                state_reg    <= S_CLR;
                            end
                            default: state_reg <= S_PUT;
                        endcase
                    end
                end
                S_PUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= rs_status_reg;
                        box_id_reg    <= rs_box_reg;
                        box_count_reg <= boxes_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                // Edge load: two list appends
                S_ADD_RD: state_reg <= S_ADD_WR;
                S_ADD_WR:
                begin
                    edge_reg      <= edge_used_reg;
                    nxt_reg       <= ht_rd.tail;
                    edge_used_reg <= edge_used_reg + 14'd1;
                    if (ht_rd.tail != gbcm_pkg::LINK_NULL)
                        state_reg <= S_ADD_LNK;
                    else if (!ph_reg)
                    begin
                        ph_reg    <= 1'b1;
                        state_reg <= S_ADD_RD;
                    end
                    else
                        state_reg <= S_PUT;
                end
                S_ADD_LNK:
                begin
                    ph_reg    <= 1'b1;
                    state_reg <= ph_reg ? S_PUT : S_ADD_RD;
                end

                // Box readout
                S_RD_ISS: state_reg <= S_RD_WAIT;
                S_RD_WAIT:
                begin
                    if (box_pos_rd)
                        rs_box_reg <= node_rd.box[10:0];
                    state_reg <= S_PUT;
                end

                // Run: reset node records
                S_INIT:
                begin
                    if (sweep_end)
                    begin
                        idx_reg     <= '0;
                        nb_reg      <= '0;
                        best_reg    <= '0;
                        best_id_reg <= '0;
                        any_unc_reg <= 1'b0;
                        state_reg   <= S_MP_RD;
                    end
                    else
                        idx_reg <= idx_reg + 11'd1;
                end

                // Excluded mass pass
                S_MP_RD:
                begin
                    if (idx_end)
                    begin
                        idx_reg <= '0;
                        if (any_unc_reg)
                        begin
                            nb_reg    <= nb_reg + 11'd1;
                            state_reg <= S_MK_RD;
                        end
                        else
                            state_reg <= S_DP_RD;
                    end
                    else
                        state_reg <= S_MP_CHK;
                end
                S_MP_CHK:
                begin
                    rec_reg <= node_rd;
                    src_reg <= idx_reg[9:0];
                    if (node_rd.box[11])
                        any_unc_reg <= 1'b1;
                    if (box_pos_rd)
                    begin
                        idx_reg   <= idx_reg + 11'd1;
                        state_reg <= S_MP_RD;
                    end
                    else
                    begin
                        mass_reg  <= (node_rd.box == gbcm_pkg::BOX_UNCOV) ? 11'd1 : 11'd0;
                        mode_reg  <= M_MASS;
                        state_reg <= S_B_START;
                    end
                end
                S_MP_END:
                begin
                    if (mass_reg > best_reg)
                    begin
                        best_reg    <= mass_reg;
                        best_id_reg <= idx_reg[9:0];
                    end
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= S_MP_RD;
                end

                // Mark the chosen centre's box
                S_MK_RD: state_reg <= S_MK_CHK;
                S_MK_CHK:
                begin
                    rec_reg   <= node_rd;
                    src_reg   <= best_id_reg;
                    mode_reg  <= M_MARK;
                    state_reg <= S_B_START;
                end
                S_MK_END:
                begin
                    idx_reg     <= '0;
                    best_reg    <= '0;
                    best_id_reg <= '0;
                    any_unc_reg <= 1'b0;
                    state_reg   <= S_MP_RD;
                end

                // Nearest centre distance pass
                S_DP_RD:
                begin
                    if (idx_end)
                    begin
                        idx_reg    <= '0;
                        t_reg      <= 7'd1;
                        fn_unc_reg <= 1'b0;
                        state_reg  <= (radius_reg == '0) ? S_FN_RD : S_AS_RD;
                    end
                    else
                        state_reg <= S_DP_CHK;
                end
                S_DP_CHK:
                begin
                    rec_reg <= node_rd;
                    src_reg <= idx_reg[9:0];
                    if (node_rd.box != '0)
                    begin
                        idx_reg   <= idx_reg + 11'd1;
                        state_reg <= S_DP_RD;
                    end
                    else
                    begin
                        mini_reg  <= radius_reg;
                        mode_reg  <= M_DIST;
                        state_reg <= S_B_START;
                    end
                end
                S_DP_END:
                begin
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= S_DP_RD;
                end

                // Layer by layer box assignment
                S_AS_RD:
                begin
                    if (idx_end)
                    begin
                        idx_reg <= '0;
                        if (t_reg == radius_reg)
                            state_reg <= S_FN_RD;
                        else
                            t_reg <= t_reg + 7'd1;
                    end
                    else
                        state_reg <= S_AS_CHK;
                end
                S_AS_CHK:
                begin
                    rec_reg  <= node_rd;
                    edge_reg <= ht_rd.head;
                    if (node_rd.box != '0 || node_rd.cdist != t_reg)
                    begin
                        idx_reg   <= idx_reg + 11'd1;
                        state_reg <= S_AS_RD;
                    end
                    else
                        state_reg <= S_AS_EDGE;
                end
                S_AS_EDGE:
                begin
                    if (edge_reg[gbcm_pkg::LINK_AW])
                    begin
                        idx_reg   <= idx_reg + 11'd1;
                        state_reg <= S_AS_RD;
                    end
                    else
                        state_reg <= S_AS_TGT;
                end
                S_AS_TGT:
                begin
                    nxt_reg <= nxt_rd;
                    if ({1'b0, tgt_rd} >= n_eff)
                    begin
                        edge_reg  <= nxt_rd;
                        state_reg <= S_AS_EDGE;
                    end
                    else
                        state_reg <= S_AS_NODE;
                end
                S_AS_NODE:
                begin
                    if ((node_rd.cdist < t_reg) && box_pos_rd)
                    begin
                        idx_reg   <= idx_reg + 11'd1;
                        state_reg <= S_AS_RD;
                    end
                    else
                    begin
                        edge_reg  <= nxt_reg;
                        state_reg <= S_AS_EDGE;
                    end
                end

                // Unassigned scan
                S_FN_RD:
                begin
                    if (idx_end)
                    begin
                        boxes_reg     <= nb_reg;
                        unseen_reg    <= fn_unc_reg;
                        rs_status_reg <= fn_unc_reg ? gbcm_pkg::ST_UNASSIGN : gbcm_pkg::ST_OK;
                        state_reg     <= S_PUT;
                    end
                    else
                        state_reg <= S_FN_CHK;
                end
                S_FN_CHK:
                begin
                    if (node_rd.box == '0)
                        fn_unc_reg <= 1'b1;
                    idx_reg   <= idx_reg + 11'd1;
                    state_reg <= S_FN_RD;
                end

                // Radius bounded burning search from src_reg
                S_B_START:
                begin
                    qlen_reg  <= 11'd1;
                    qhead_reg <= '0;
                    state_reg <= S_B_POP;
                end
                S_B_POP:
                begin
                    if (qhead_reg == qlen_reg)
                    begin
                        qhead_reg <= '0;
                        state_reg <= S_U_RD;
                    end
                    else
                    begin
                        qhead_reg <= qhead_reg + 11'd1;
                        state_reg <= S_B_POPW;
                    end
                end
                S_B_POPW: state_reg <= S_B_TREC;
                S_B_TREC:
                begin
                    hopt_reg <= node_rd.hop;
                    edge_reg <= ht_rd.head;
                    state_reg <= (node_rd.hop >= {1'b0, radius_reg}) ? S_B_POP : S_B_EDGE;
                end
                S_B_EDGE:
                    state_reg <= edge_reg[gbcm_pkg::LINK_AW] ? S_B_POP : S_B_TGT;
                S_B_TGT:
                begin
                    nxt_reg <= nxt_rd;
                    h_reg   <= tgt_rd;
                    if ({1'b0, tgt_rd} >= n_eff)
                    begin
                        edge_reg  <= nxt_rd;
                        state_reg <= S_B_EDGE;
                    end
                    else
                        state_reg <= S_B_NODE;
                end
                S_B_NODE:
                begin
                    edge_reg  <= nxt_reg;
                    state_reg <= S_B_EDGE;
                    if (!burn_rd)
                    begin
                        qlen_reg <= qlen_reg + 11'd1;
                        if (mode_reg == M_MASS && node_rd.box == gbcm_pkg::BOX_UNCOV)
                            mass_reg <= mass_reg + 11'd1;
                        if (mode_reg == M_DIST && box_pos_rd &&
                            {1'b0, hop_new} < {2'b0, mini_reg})
                            mini_reg <= hop_new[6:0];
                    end
                end

                // Clear burnt marks of every queued node
                S_U_RD:
                begin
                    if (qhead_reg == qlen_reg)
                    begin
                        unique case (mode_reg)
                            M_MASS:  state_reg <= S_MP_END;
                            M_MARK:  state_reg <= S_MK_END;
                            default: state_reg <= S_DP_END;
                        endcase
                    end
                    else
                    begin
                        qhead_reg <= qhead_reg + 11'd1;
                        state_reg <= S_U_WR;
                    end
                end
                S_U_WR: state_reg <= S_U_RD;

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
